@@ design/wobg_pkg.sv @@
// shared types, constants and helpers of the write-once block guard
`timescale 1ns / 1ps

package wobg_pkg;

    localparam int ADDR_W             = 16;
    localparam int SIZE_W             = 17;
    localparam int BITS_PER_MAP_BLOCK = 65536;
    localparam int MAP_SHIFT          = $clog2(BITS_PER_MAP_BLOCK);
    localparam int ADDR_SPACE         = 1 << ADDR_W;
    localparam int ROW_WIDTH          = 64;
    localparam int ROW_SHIFT          = $clog2(ROW_WIDTH);
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [SIZE_W-1:0] DEVICE_SIZE_RESET = 17'd65538;

    localparam logic       KIND_READ  = 1'b0;
    localparam logic       KIND_WRITE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;

    typedef struct packed {
        logic              kind;
        logic              out_of_range;
        logic [ADDR_W-1:0] block_address;
        logic [SIZE_W-1:0] map_block;
    } t_item;

    // data blocks left once the bitmap blocks are taken off the top
    function automatic logic [SIZE_W-1:0] usable_of(input logic [SIZE_W-1:0] dev);
        logic [SIZE_W-1:0] overhead;
        overhead = (dev >> MAP_SHIFT) + SIZE_W'(1);
        return (dev < overhead) ? '0 : dev - overhead;
    endfunction

endpackage

@@ design/wobg_front.sv @@
// front end: size register, range check and map block of each item
`timescale 1ns / 1ps

module wobg_front import wobg_pkg::*; #(
    parameter int MAX_BLOCKS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_block_address,
    output t_item             o_item
);

    logic [SIZE_W-1:0] r_usable;
    logic              beyond_store;
    logic              beyond_usable;

    // usable size kept precomputed, it changes only on reset or a size write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_usable <= usable_of(DEVICE_SIZE_RESET);
        end else if (i_cfg_wr_en) begin
            r_usable <= usable_of(i_cfg_wr_data);
        end
    end

    assign beyond_store  = {16'd0, i_block_address} >= 32'(MAX_BLOCKS);
    assign beyond_usable = {1'b0, i_block_address} >= r_usable;

    always_comb begin
        o_item.kind          = i_kind;
        o_item.block_address = i_block_address;
        o_item.out_of_range  = beyond_store || beyond_usable;
        o_item.map_block     = o_item.out_of_range ? '0 :
            SIZE_W'(r_usable + SIZE_W'(i_block_address >> MAP_SHIFT));
    end

endmodule

@@ design/wobg_queue.sv @@
// short item queue between front and back
`timescale 1ns / 1ps

module wobg_queue import wobg_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_push_item,
    output logic  o_not_full,
    input  logic  i_pop,
    output logic  o_not_empty,
    output t_item o_pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_slots [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_not_full  = r_count != CNT_W'(QUEUE_DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_pop_item  = r_slots[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

@@ design/wobg_back.sv @@
// back end: bitmap memory, clearing pass and read-modify-write per item
`timescale 1ns / 1ps

module wobg_back import wobg_pkg::*; #(
    parameter int MAX_BLOCKS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_have_item,
    input  t_item             i_item,
    output logic              o_take_item,
    output logic              o_clearing,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [SIZE_W-1:0] o_map_block
);

    localparam int STORE_DEPTH = (MAX_BLOCKS < ADDR_SPACE) ? MAX_BLOCKS : ADDR_SPACE;
    localparam int NUM_ROWS    = (STORE_DEPTH + ROW_WIDTH - 1) / ROW_WIDTH;
    localparam int ROW_IDX_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EVAL
    } t_state;

    t_state               r_state;
    logic [ROW_IDX_W-1:0] r_clr_row;
    t_item                r_item;
    logic [ROW_WIDTH-1:0] r_bitmap [NUM_ROWS];
    logic [ROW_WIDTH-1:0] r_rd_data;

    logic                 mem_re;
    logic                 mem_we;
    logic [ROW_IDX_W-1:0] rd_row;
    logic [ROW_IDX_W-1:0] wr_row;
    logic [ROW_WIDTH-1:0] wr_data;
    logic                 was_written;
    logic                 out_free;
    logic                 sets_bit;
    logic [1:0]           n_status;

    assign rd_row      = ROW_IDX_W'(i_item.block_address >> ROW_SHIFT);
    assign was_written = r_rd_data[r_item.block_address[ROW_SHIFT-1:0]];
    assign out_free    = !o_valid || i_ready;
    assign o_clearing  = r_state == S_CLEAR;
    assign o_take_item = (r_state == S_IDLE) && i_have_item;
    assign mem_re      = o_take_item && !i_item.out_of_range;
    assign sets_bit    = !r_item.out_of_range && (r_item.kind == KIND_WRITE) && !was_written;

    always_comb begin
        if (r_item.out_of_range) begin
            n_status = ST_RANGE;
        end else if (r_item.kind == KIND_READ) begin
            n_status = was_written ? ST_OK : ST_REFUSED;
        end else begin
            n_status = was_written ? ST_REFUSED : ST_OK;
        end
    end

    always_comb begin
        mem_we  = 1'b0;
        wr_row  = ROW_IDX_W'(r_item.block_address >> ROW_SHIFT);
        wr_data = r_rd_data | (ROW_WIDTH'(1) << r_item.block_address[ROW_SHIFT-1:0]);
        case (r_state)
            S_CLEAR: begin
                mem_we  = 1'b1;
                wr_row  = r_clr_row;
                wr_data = '0;
            end
            S_EVAL: begin
                mem_we = out_free && sets_bit;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_bitmap[wr_row] <= wr_data;
        end
        if (mem_re) begin
            r_rd_data <= r_bitmap[rd_row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_row <= '0;
            o_valid   <= 1'b0;
        end else begin
            // result register: load a finished item, or drop the one just taken
            if ((r_state == S_EVAL) && out_free) begin
                o_valid     <= 1'b1;
                o_status    <= n_status;
                o_map_block <= r_item.map_block;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_row <= r_clr_row + ROW_IDX_W'(1);
                    if (r_clr_row == ROW_IDX_W'(NUM_ROWS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_have_item) begin
                        r_item  <= i_item;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/write_once_block_guard_core.sv @@
// top level of the write-once block guard: front, queue and back
`timescale 1ns / 1ps

// channel | handshake          | payload
// --------+--------------------+-------------------------------------
// in      | i_valid / o_ready  | i_kind, i_block_address
// out     | o_valid / i_ready  | o_status, o_map_block
// cfg     | i_cfg_wr_en        | i_cfg_wr_data (device size)
//
// the back end takes one item at a time: S_IDLE reads its bitmap row, S_EVAL then
// makes the status decision and the row write-back and waits while the output stalls;
// an accepted item passes the queue, the S_IDLE row read and S_EVAL to reach o_valid
// after reset a clearing pass writes zero to the bitmap one 64-bit row a cycle,
// over ceil(min(MAX_BLOCKS, 65536) / 64) rows (1024 at the default); o_ready stays low
// a two-item queue lets the front keep accepting while the output stalls, until it is full

module write_once_block_guard_core import wobg_pkg::*; #(
    parameter int MAX_BLOCKS = 65536
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [SIZE_W-1:0] i_cfg_wr_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [ADDR_W-1:0] i_block_address,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [SIZE_W-1:0] o_map_block
);

    t_item front_item;
    t_item queue_item;
    logic  queue_not_full;
    logic  queue_not_empty;
    logic  back_take;
    logic  clearing;
    logic  accept;

    // no item is taken while the bitmap is still being cleared
    assign o_ready = queue_not_full && !clearing;
    assign accept  = i_valid && o_ready;

    // front end classifies the item in the cycle it is accepted
    wobg_front #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_kind          (i_kind),
        .i_block_address (i_block_address),
        .o_item          (front_item)
    );

    // classified items wait here for the back end
    wobg_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_push_item (front_item),
        .o_not_full  (queue_not_full),
        .i_pop       (back_take),
        .o_not_empty (queue_not_empty),
        .o_pop_item  (queue_item)
    );

    // back end owns the written-bit memory and the result register
    wobg_back #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_have_item (queue_not_empty),
        .i_item      (queue_item),
        .o_take_item (back_take),
        .o_clearing  (clearing),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_map_block (o_map_block)
    );

endmodule
